>>> rtl/sns_pkg.sv
// ----------------------------------------------------------------------------
// Strongest neighbour select package
// Shared constants, outcome codes and controller command types.
// ----------------------------------------------------------------------------
package sns_pkg;

	localparam int NODE_COUNT_DEF    = 65536;
	localparam int VALUE_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int IDX_W = 16;
	localparam int AGG_W = 17;

	typedef enum logic [1:0] {
		OUT_ALREADY  = 2'd0,
		OUT_JOINED   = 2'd1,
		OUT_STRONG   = 2'd2,
		OUT_ISOLATED = 2'd3
	} outcome_t;

	typedef struct packed {
		logic load;
		logic step;
		logic update;
		logic clear;
	} sns_cmd_t;

	typedef struct packed {
		logic div_done;
		logic scored;
		logic last;
	} sns_sts_t;

endpackage

>>> rtl/sns_ctrl.sv
// ----------------------------------------------------------------------------
// Strongest neighbour select controller
// Sequences operand load, the serial division, the update and the result.
// ----------------------------------------------------------------------------
module sns_ctrl
	import sns_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  sns_sts_t sts,
	output sns_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q;
	logic   accept, out_valid_q, out_hold, upd_wait;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign out_hold  = out_valid_q && out_stall;
	assign upd_wait  = (state_q == S_UPD) && sts.last && out_hold;

	always_comb begin
		cmd.load   = accept;
		cmd.step   = (state_q == S_DIV);
		cmd.update = (state_q == S_UPD) && !upd_wait;
		cmd.clear  = (state_q == S_UPD) && sts.last && !out_hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= sts.scored ? S_DIV : S_UPD;
				S_DIV:  if (sts.div_done) state_q <= S_UPD;
				S_UPD:  if (!upd_wait) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (cmd.clear) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/sns_datapath.sv
// ----------------------------------------------------------------------------
// Strongest neighbour select datapath
// Restoring divider, running maxima and result formation.
// ----------------------------------------------------------------------------
module sns_datapath
	import sns_pkg::*;
#(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rule_mode,
	input  sns_cmd_t                      cmd,
	output sns_sts_t                      sts,
	input  logic [IDX_W-1:0]              row_index,
	input  logic signed [AGG_W-1:0]       row_aggregate,
	input  logic                          has_entry,
	input  logic [IDX_W-1:0]              neighbor_column,
	input  logic signed [VALUE_WIDTH-1:0] edge_weight,
	input  logic signed [VALUE_WIDTH-1:0] row_diagonal,
	input  logic signed [VALUE_WIDTH-1:0] neighbor_diagonal,
	input  logic signed [AGG_W-1:0]       neighbor_aggregate,
	input  logic                          last_entry,
	output logic [IDX_W-1:0]              result_row,
	output logic [1:0]                    outcome,
	output logic [IDX_W-1:0]              chosen_node
);

	localparam int VW = VALUE_WIDTH;
	localparam int NW = VW + FRACTION_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam logic signed [VW-1:0] MAXPOS = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] MINNEG = {1'b1, {(VW-1){1'b0}}};
	localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

	logic [VW-1:0]            da, db, dmax, nmag;
	logic                     in_range, scored;
	logic [NW-1:0]            num_q;
	logic [VW:0]              rem_q, rem_sh, rem_sub;
	logic [VW-1:0]            div_q;
	logic [CW-1:0]            cnt_q;
	logic                     neg_q, wz_q, dz_q, free_q, last_q, agg_row_q;
	logic                     sts_scored_q;
	logic [IDX_W-1:0]         row_q, col_q;
	logic [AGG_W-1:0]         nagg_q, ragg_q;
	logic signed [VW-1:0]     score;
	logic [NW:0]              quo_full;
	logic signed [VW-1:0]     bf_ratio_q, bj_ratio_q;
	logic signed [AGG_W-1:0]  bf_col_q, bj_col_q, bj_grp_q;
	logic signed [AGG_W-1:0]  col_ext;
	logic [NW-1:0]            quo_q;

	assign da   = row_diagonal[VW-1] ? VW'(-row_diagonal) : VW'(row_diagonal);
	assign db   = neighbor_diagonal[VW-1] ? VW'(-neighbor_diagonal) : VW'(neighbor_diagonal);
	assign dmax = (da > db) ? da : db;
	assign nmag = edge_weight[VW-1] ? VW'(-edge_weight) : VW'(edge_weight);
	assign in_range = (34'(neighbor_column) < 34'(NODE_COUNT));
	assign scored = (row_aggregate == -17'sd1) && has_entry
		&& (neighbor_column != row_index) && in_range;

	assign sts.scored   = scored;
	assign sts.div_done = (cnt_q == LAST_STEP);
	assign sts.last     = last_q;

	assign rem_sh  = {rem_q[VW-1:0], num_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q     <= {nmag, {FRACTION_BITS{1'b0}}};
			rem_q     <= '0;
			quo_q     <= '0;
			div_q     <= dmax;
			cnt_q     <= '0;
			neg_q     <= edge_weight[VW-1];
			wz_q      <= (edge_weight == '0);
			dz_q      <= (dmax == '0);
			free_q    <= (neighbor_aggregate == -17'sd1);
			last_q    <= last_entry;
			agg_row_q <= (row_aggregate != -17'sd1);
			row_q     <= row_index;
			col_q     <= neighbor_column;
			nagg_q    <= neighbor_aggregate;
			ragg_q    <= row_aggregate;
		end else if (cmd.step) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			cnt_q <= cnt_q + CW'(1);
			if (!rem_sub[VW]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo_full = {1'b0, quo_q};
	always_comb begin
		if (dz_q) begin
			score = wz_q ? '0 : (neg_q ? MINNEG : MAXPOS);
		end else if (neg_q) begin
			score = (quo_full > (NW+1)'({1'b1, {(VW-1){1'b0}}})) ? MINNEG
				: VW'(-quo_q[VW-1:0]);
		end else begin
			score = (quo_full > (NW+1)'(MAXPOS)) ? MAXPOS : VW'(quo_q[VW-1:0]);
		end
	end

	assign col_ext = $signed({1'b0, col_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_ratio_q <= '0;
			bf_col_q   <= -17'sd1;
			bj_ratio_q <= '0;
			bj_col_q   <= -17'sd1;
			bj_grp_q   <= -17'sd1;
		end else if (cmd.update) begin
			if (cmd.clear) begin
				bf_ratio_q <= '0;
				bf_col_q   <= -17'sd1;
				bj_ratio_q <= '0;
				bj_col_q   <= -17'sd1;
				bj_grp_q   <= -17'sd1;
			end else if (!agg_row_q && sts_scored_q) begin
				if (free_q) begin
					if (score > bf_ratio_q || (score == bf_ratio_q && col_ext > bf_col_q)) begin
						bf_ratio_q <= score;
						bf_col_q   <= col_ext;
					end
				end else if (score > bj_ratio_q
						|| (score == bj_ratio_q && col_ext > bj_col_q)) begin
					bj_ratio_q <= score;
					bj_col_q   <= col_ext;
					bj_grp_q   <= $signed(nagg_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) sts_scored_q <= scored;
	end

	logic                   f_ok, j_ok, f_take, j_take;
	logic [1:0]             oc_d;
	logic [IDX_W-1:0]       ch_d;

	always_comb begin
		f_take = 1'b0; j_take = 1'b0;
		if (sts_scored_q && !agg_row_q) begin
			if (free_q) f_take = (score > bf_ratio_q)
				|| (score == bf_ratio_q && col_ext > bf_col_q);
			else j_take = (score > bj_ratio_q)
				|| (score == bj_ratio_q && col_ext > bj_col_q);
		end
		f_ok = f_take || (bf_col_q != -17'sd1);
		j_ok = j_take || (bj_col_q != -17'sd1);
		if (agg_row_q) begin
			oc_d = OUT_ALREADY;
			ch_d = ragg_q[IDX_W-1:0];
		end else if (j_ok && (rule_mode || !f_ok)) begin
			oc_d = OUT_JOINED;
			ch_d = j_take ? nagg_q[IDX_W-1:0] : bj_grp_q[IDX_W-1:0];
		end else if (!rule_mode && f_ok) begin
			oc_d = OUT_STRONG;
			ch_d = f_take ? col_q : bf_col_q[IDX_W-1:0];
		end else begin
			oc_d = OUT_ISOLATED;
			ch_d = row_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			result_row  <= row_q;
			outcome     <= oc_d;
			chosen_node <= ch_d;
		end
	end

endmodule

>>> rtl/strongest_neighbor_select.sv
// ----------------------------------------------------------------------------
// Strongest neighbour select
// A skipped entry goes from idle straight to update; a scored entry runs the
// division first (one quotient bit per cycle from the restoring divider); the
// result is valid in the cycle after the last entry's update. A result held by
// the receiver only delays the update of the next row's last entry. Reset clears
// the controller, the result flag, the running maxima and the mode register.
// ----------------------------------------------------------------------------
module strongest_neighbor_select
	import sns_pkg::*;
#(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [IDX_W-1:0]              row_index,
	input  logic signed [AGG_W-1:0]       row_aggregate,
	input  logic                          has_entry,
	input  logic [IDX_W-1:0]              neighbor_column,
	input  logic signed [VALUE_WIDTH-1:0] edge_weight,
	input  logic signed [VALUE_WIDTH-1:0] row_diagonal,
	input  logic signed [VALUE_WIDTH-1:0] neighbor_diagonal,
	input  logic signed [AGG_W-1:0]       neighbor_aggregate,
	input  logic                          last_entry,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [IDX_W-1:0]              result_row,
	output logic [1:0]                    outcome,
	output logic [IDX_W-1:0]              chosen_node
);

	logic     rule_mode_q;
	sns_cmd_t cmd;
	sns_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rule_mode_q <= 1'b0;
		else if (cfg_we) rule_mode_q <= cfg_wdata;
	end

	sns_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	sns_datapath #(
		.NODE_COUNT(NODE_COUNT), .VALUE_WIDTH(VALUE_WIDTH), .FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk, .arst_n, .rule_mode(rule_mode_q), .cmd, .sts,
		.row_index, .row_aggregate, .has_entry, .neighbor_column, .edge_weight,
		.row_diagonal, .neighbor_diagonal, .neighbor_aggregate, .last_entry,
		.result_row, .outcome, .chosen_node
	);

	a_clear_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !(out_valid && out_stall)) else $error("result overwritten");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(chosen_node))
		else $error("result changed under stall");
	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> out_valid) else $error("clear without result");

endmodule

>>> tb/sv/sns_checker.sv
// ----------------------------------------------------------------------------
// Strongest neighbour select checker
// Watches both channels, predicts each row decision from the accepted entry
// transfers and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module sns_checker
	import sns_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [IDX_W-1:0]        row_index,
	input  logic signed [AGG_W-1:0] row_aggregate,
	input  logic                    has_entry,
	input  logic [IDX_W-1:0]        neighbor_column,
	input  logic signed [31:0]      edge_weight,
	input  logic signed [31:0]      row_diagonal,
	input  logic signed [31:0]      neighbor_diagonal,
	input  logic signed [AGG_W-1:0] neighbor_aggregate,
	input  logic                    last_entry,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [IDX_W-1:0]        result_row,
	input  logic [1:0]              outcome,
	input  logic [IDX_W-1:0]        chosen_node,
	output int                      fail_count,
	output int                      pending,
	output int                      decisions_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		outcome_t         code;
		logic [IDX_W-1:0] node;
	} decision_t;

	decision_t decision_q[$];
	logic mode;
	longint free_ratio, joined_ratio;
	int free_col, joined_col, joined_grp;

	function automatic longint ratio_q16(longint w, longint a, longint b);
		longint d, n, q;
		d = (a < 0 ? -a : a) > (b < 0 ? -b : b) ? (a < 0 ? -a : a) : (b < 0 ? -b : b);
		n = w < 0 ? -w : w;
		if (d == 0)
			return w > 0 ? 64'sd2147483647 : (w < 0 ? -64'sd2147483648 : 0);
		q = (n <<< 16) / d;
		if (w < 0)
			return q > 64'sd2147483648 ? -64'sd2147483648 : -q;
		return q > 64'sd2147483647 ? 64'sd2147483647 : q;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		decision_t d, e;
		longint s;
		if (!arst_n) begin
			mode = 1'b0;
			free_ratio = 0; free_col = -1;
			joined_ratio = 0; joined_col = -1; joined_grp = -1;
			decision_q.delete();
			fail_count = 0;
			decisions_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				decisions_seen++;
				if (decision_q.size() == 0) begin
					report("unexpected result row", 32'(result_row), 32'd0);
				end else begin
					e = decision_q.pop_front();
					if (result_row !== e.row)
						report("result_row", 32'(result_row), 32'(e.row));
					if (outcome !== e.code)
						report("outcome", 32'(outcome), 32'(e.code));
					if (chosen_node !== e.node)
						report("chosen_node", 32'(chosen_node), 32'(e.node));
				end
			end
			if (in_valid && !in_stall) begin
				if (row_aggregate == -1 && has_entry && neighbor_column != row_index) begin
					s = ratio_q16(edge_weight, row_diagonal, neighbor_diagonal);
					if (neighbor_aggregate == -1) begin
						if (s > free_ratio || (s == free_ratio && int'(neighbor_column) > free_col)) begin
							free_ratio = s; free_col = neighbor_column;
						end
					end else if (s > joined_ratio ||
							(s == joined_ratio && int'(neighbor_column) > joined_col)) begin
						joined_ratio = s; joined_col = neighbor_column;
						joined_grp = neighbor_aggregate;
					end
				end
				if (last_entry) begin
					d.row = row_index;
					if (row_aggregate != -1) begin
						d.code = OUT_ALREADY; d.node = row_aggregate[15:0];
					end else if (joined_col != -1 && (mode || free_col == -1)) begin
						d.code = OUT_JOINED; d.node = joined_grp[15:0];
					end else if (!mode && free_col != -1) begin
						d.code = OUT_STRONG; d.node = free_col[15:0];
					end else begin
						d.code = OUT_ISOLATED; d.node = row_index;
					end
					decision_q.push_back(d);
					free_ratio = 0; free_col = -1;
					joined_ratio = 0; joined_col = -1; joined_grp = -1;
				end
			end
			if (cfg_we) mode = cfg_wdata;
		end
		pending = decision_q.size();
	end
endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Strongest neighbour select testbench
// Streams directed and random rows through the selector under both rules and
// several idling phases; the checker predicts and compares every decision.
// ----------------------------------------------------------------------------
module tb
	import sns_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0, arst_n = 1'b0;
	logic cfg_we = 1'b0, cfg_wdata = 1'b0;
	logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
	logic [IDX_W-1:0] row_index = '0, neighbor_column = '0;
	logic signed [AGG_W-1:0] row_aggregate = -17'sd1, neighbor_aggregate = -17'sd1;
	logic has_entry = 1'b0, last_entry = 1'b0;
	logic signed [31:0] edge_weight = '0, row_diagonal = '0, neighbor_diagonal = '0;
	logic [1:0] outcome;
	logic [IDX_W-1:0] result_row, chosen_node;
	int fail_count, pending, decisions_seen;
	int send_idle = 0, recv_stall = 0, hold_off = 0, idle_cycles = 0, sent = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	strongest_neighbor_select uut (.*);
	sns_checker chk (.*);

	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_entry(input logic [15:0] r, input logic signed [16:0] ra, input logic he,
			input logic [15:0] c, input logic signed [31:0] w, d1, d2,
			input logic signed [16:0] na, input logic le);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		row_index <= r; row_aggregate <= ra; has_entry <= he; neighbor_column <= c;
		edge_weight <= w; row_diagonal <= d1; neighbor_diagonal <= d2;
		neighbor_aggregate <= na; last_entry <= le; in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic random_row();
		logic [15:0] r, c;
		logic signed [16:0] ra, na;
		int n;
		r = 16'($urandom);
		ra = ($urandom_range(9) == 0) ? $signed(17'($urandom)) : -17'sd1;
		n = $urandom_range(6);
		if (n == 0) begin
			send_entry(r, ra, 1'b0, 16'($urandom), $urandom, $urandom, $urandom,
				$signed(17'($urandom)), 1'b1);
			return;
		end
		for (int i = 0; i < n; i++) begin
			c = ($urandom_range(7) == 0) ? r : 16'($urandom);
			na = ($urandom_range(2) == 0) ? $signed(17'($urandom)) : -17'sd1;
			send_entry(r, ra, $urandom_range(9) != 0, c, pick_value(), pick_value(),
				pick_value(), na, i == n - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		cfg_we <= 1'b1; cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Directed rows: extremes, ties, self entries, zero divisors, placeholders.
		send_entry(16'd5, -17'sd1, 1'b0, 16'd0, 32'sd0, 32'sd0, 32'sd0, -17'sd1, 1'b1);
		send_entry(16'hffff, 17'sd65535, 1'b1, 16'd3, 32'sh10000, 32'sh10000, 32'sh10000,
			-17'sd1, 1'b1);
		send_entry(16'd7, -17'sd2, 1'b1, 16'd3, 32'sh10000, 32'sh10000, 32'sh10000,
			-17'sd1, 1'b1);
		send_entry(16'd1, -17'sd1, 1'b1, 16'd1, 32'sh7fffffff, 32'sd1, 32'sd1, -17'sd1, 1'b0);
		send_entry(16'd1, -17'sd1, 1'b1, 16'd9, 32'sh10000, 32'sd0, 32'sd0, -17'sd1, 1'b0);
		send_entry(16'd1, -17'sd1, 1'b1, 16'd4, 32'sh10000, 32'sd0, 32'sd0, -17'sd1, 1'b0);
		send_entry(16'd1, -17'sd1, 1'b1, 16'hffff, 32'sh80000000, 32'sd0, 32'sd0,
			-17'sd1, 1'b1);
		send_entry(16'd2, -17'sd1, 1'b1, 16'd8, 32'sh20000, 32'sh80000000, 32'sh10000,
			17'sd65535, 1'b0);
		send_entry(16'd2, -17'sd1, 1'b1, 16'd3, 32'sh7fffffff, 32'sh10000, 32'sh7fffffff,
			-17'sd1, 1'b1);
		send_entry(16'd4, -17'sd1, 1'b1, 16'd6, -32'sh10000, 32'sh10000, 32'sd1, -17'sd1, 1'b0);
		send_entry(16'd4, -17'sd1, 1'b1, 16'd0, 32'sh8000, 32'sh10000, -32'sh10000,
			-17'sd7, 1'b1);
		drain();
		set_mode(1'b1);
		send_entry(16'd3, -17'sd1, 1'b1, 16'd8, 32'sh20000, 32'sh10000, 32'sh10000,
			-17'sd1, 1'b0);
		send_entry(16'd3, -17'sd1, 1'b1, 16'd9, 32'sh100, 32'sh10000, 32'sh10000,
			17'sd42, 1'b1);
		send_entry(16'd6, -17'sd1, 1'b1, 16'd8, 32'sh20000, 32'sh10000, 32'sh10000,
			-17'sd1, 1'b1);
		drain();
		set_mode(1'b0);
		for (int ph = 0; ph < 8; ph++) begin
			send_idle = (ph % 4 == 1 || ph % 4 == 3) ? 65 : 0;
			recv_stall = (ph % 4 == 2) ? 65 : (ph % 4 == 3) ? 37 : 0;
			if (ph % 4 == 3) send_idle = 37;
			if (ph == 2) hold_off = 400;
			for (int k = 0; k < 16; k++) random_row();
			drain();
			set_mode(ph % 2 == 0);
		end
		$display("Sent %0d entry transfers; %0d decisions checked under both rules.",
			sent, decisions_seen);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
